@@ design/nmds_pkg.sv @@
// Shared types, widths and constants of the normal-mapped diffuse shader.
package nmds_pkg;

   localparam int NUM_AXES   = 3;
   localparam int COMP_W     = 8;                        // texel byte
   localparam int FRAC_W     = 14;                       // Q1.14 fraction bits
   localparam int SQ_W       = 18;                       // sum of three squared bytes
   localparam int ROOT_W     = (SQ_W + 2 * FRAC_W) / 2;  // sqrt of q << 28
   localparam int REM_W      = ROOT_W + 1;               // sqrt remainder
   localparam int QUOT_W     = 15;                       // unit component magnitude
   localparam int DIV_PRE    = 2 * FRAC_W - QUOT_W;      // first divider remainder shift
   localparam int CFG_W      = 16;
   localparam int PROD_W     = 2 * CFG_W;                // component times direction
   localparam int GAIN_SHIFT = 26;
   localparam int SCALED_W   = PROD_W - 1 + CFG_W;       // positive dot times gain
   localparam int INTENS_W   = FRAC_W + 1;               // 0..1.0 in Q.14
   localparam int SHADE_W    = COMP_W + INTENS_W;
   localparam int CSR_IDX_W  = 2;

   localparam logic [INTENS_W-1:0] INTENS_ONE = INTENS_W'(16384);

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LIGHT_DIR_X,
      CSR_LIGHT_DIR_Y,
      CSR_LIGHT_DIR_Z,
      CSR_LIGHT_GAIN
   } nmds_csr_type;

   typedef struct packed {
      logic [COMP_W-1:0] red;
      logic [COMP_W-1:0] green;
      logic [COMP_W-1:0] blue;
   } nmds_rgb_type;

   // normal as sign and magnitude of 2c-255 per axis, plus the diffuse texel
   typedef struct packed {
      logic [NUM_AXES-1:0]              neg;
      logic [NUM_AXES-1:0][COMP_W-1:0]  mag;
      nmds_rgb_type                     diffuse;
   } nmds_frag_type;

   typedef struct packed {
      logic signed [CFG_W-1:0] dir_x;
      logic signed [CFG_W-1:0] dir_y;
      logic signed [CFG_W-1:0] dir_z;
      logic        [CFG_W-1:0] gain;
   } nmds_light_type;

   localparam nmds_light_type LIGHT_RESET = '{
      dir_x: 16'sd0,
      dir_y: 16'sd0,
      dir_z: 16'sd16384,
      gain:  16'd4096
   };

   // |2c - 255|, always odd
   function automatic logic [COMP_W-1:0] nmds_mag(input logic [COMP_W-1:0] c);
      logic [COMP_W-1:0] m;
      if (c[COMP_W-1]) begin
         m = {c[COMP_W-2:0], 1'b1};
      end else begin
         m = {~c[COMP_W-2:0], 1'b1};
      end
      return m;
   endfunction

endpackage

@@ design/nmds_if.sv @@
// Request and response channel interfaces of the diffuse shader.
interface nmds_req_if;
   logic                            valid;
   logic                            ready;
   logic [nmds_pkg::COMP_W-1:0]     normal_red;
   logic [nmds_pkg::COMP_W-1:0]     normal_green;
   logic [nmds_pkg::COMP_W-1:0]     normal_blue;
   logic [nmds_pkg::COMP_W-1:0]     diffuse_red;
   logic [nmds_pkg::COMP_W-1:0]     diffuse_green;
   logic [nmds_pkg::COMP_W-1:0]     diffuse_blue;

   modport source (
      output valid, normal_red, normal_green, normal_blue,
             diffuse_red, diffuse_green, diffuse_blue,
      input  ready
   );
   modport sink (
      input  valid, normal_red, normal_green, normal_blue,
             diffuse_red, diffuse_green, diffuse_blue,
      output ready
   );
endinterface

interface nmds_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [nmds_pkg::COMP_W-1:0]     shaded_red;
   logic [nmds_pkg::COMP_W-1:0]     shaded_green;
   logic [nmds_pkg::COMP_W-1:0]     shaded_blue;

   modport source (
      output valid, shaded_red, shaded_green, shaded_blue,
      input  ready
   );
   modport sink (
      input  valid, shaded_red, shaded_green, shaded_blue,
      output ready
   );
endinterface

@@ design/nmds_sqrt.sv @@
// Pipelined integer square root of (squared normal length << 28), one root bit per stage.
module nmds_sqrt (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            enable,
   input  logic                            in_valid,
   input  nmds_pkg::nmds_frag_type         in_frag,
   output logic                            out_valid,
   output nmds_pkg::nmds_frag_type         out_frag,
   output logic [nmds_pkg::ROOT_W-1:0]     out_root
);

   localparam int N = nmds_pkg::ROOT_W;

   logic                            sq_valid_ff [0:N];
   logic                            sq_valid_in [0:N];
   nmds_pkg::nmds_frag_type         sq_frag_ff  [0:N];
   nmds_pkg::nmds_frag_type         sq_frag_in  [0:N];
   logic [nmds_pkg::SQ_W-1:0]       sq_q_ff     [0:N-1];
   logic [nmds_pkg::SQ_W-1:0]       sq_q_in     [0:N-1];
   logic [nmds_pkg::REM_W-1:0]      sq_rem_ff   [0:N];
   logic [nmds_pkg::REM_W-1:0]      sq_rem_in   [0:N];
   logic [nmds_pkg::ROOT_W-1:0]     sq_root_ff  [0:N];
   logic [nmds_pkg::ROOT_W-1:0]     sq_root_in  [0:N];

   // stage 0: squared length of the unnormalized vector
   assign sq_valid_in[0] = in_valid;
   assign sq_frag_in[0]  = in_frag;
   assign sq_q_in[0]     = nmds_pkg::SQ_W'(in_frag.mag[0]) * nmds_pkg::SQ_W'(in_frag.mag[0])
                         + nmds_pkg::SQ_W'(in_frag.mag[1]) * nmds_pkg::SQ_W'(in_frag.mag[1])
                         + nmds_pkg::SQ_W'(in_frag.mag[2]) * nmds_pkg::SQ_W'(in_frag.mag[2]);
   assign sq_rem_in[0]   = '0;
   assign sq_root_in[0]  = '0;

   for (genvar s = 0; s < N; s++) begin : g_step
      localparam int Bit = N - 1 - s;
      logic [2*N-1:0]                  radicand;
      logic [nmds_pkg::REM_W+1:0]      cur;
      logic [nmds_pkg::REM_W+1:0]      trial;
      logic [nmds_pkg::REM_W+1:0]      diff;
      logic                            take;

      assign radicand = {sq_q_ff[s], {(2 * nmds_pkg::FRAC_W){1'b0}}};
      assign cur      = {sq_rem_ff[s], radicand[2*Bit+1 -: 2]};
      assign trial    = {1'b0, sq_root_ff[s], 2'b01};
      assign diff     = cur - trial;
      assign take     = (cur >= trial);

      assign sq_valid_in[s+1] = sq_valid_ff[s];
      assign sq_frag_in[s+1]  = sq_frag_ff[s];
      assign sq_rem_in[s+1]   = take ? diff[nmds_pkg::REM_W-1:0] : cur[nmds_pkg::REM_W-1:0];
      assign sq_root_in[s+1]  = {sq_root_ff[s][N-2:0], take};
      if (s < N - 1) begin : g_q
         assign sq_q_in[s+1] = sq_q_ff[s];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sq_valid_ff <= '{default: 1'b0};
      end else if (enable) begin
         sq_valid_ff <= sq_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         sq_frag_ff <= sq_frag_in;
         sq_q_ff    <= sq_q_in;
         sq_rem_ff  <= sq_rem_in;
         sq_root_ff <= sq_root_in;
      end
   end

   assign out_valid = sq_valid_ff[N];
   assign out_frag  = sq_frag_ff[N];
   assign out_root  = sq_root_ff[N];

endmodule

@@ design/nmds_div.sv @@
// Pipelined three-lane restoring divider: |u| * 2^28 / root, one quotient bit per stage.
module nmds_div (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  logic                                                    enable,
   input  logic                                                    in_valid,
   input  nmds_pkg::nmds_frag_type                                 in_frag,
   input  logic [nmds_pkg::ROOT_W-1:0]                             in_root,
   output logic                                                    out_valid,
   output nmds_pkg::nmds_frag_type                                 out_frag,
   output logic [nmds_pkg::NUM_AXES-1:0][nmds_pkg::QUOT_W-1:0]     out_quot
);

   localparam int N = nmds_pkg::QUOT_W;

   typedef logic [nmds_pkg::NUM_AXES-1:0][nmds_pkg::ROOT_W-1:0] rem_type;
   typedef logic [nmds_pkg::NUM_AXES-1:0][nmds_pkg::QUOT_W-1:0] quot_type;

   logic                            dv_valid_ff [1:N];
   logic                            dv_valid_in [1:N];
   nmds_pkg::nmds_frag_type         dv_frag_ff  [1:N];
   nmds_pkg::nmds_frag_type         dv_frag_in  [1:N];
   logic [nmds_pkg::ROOT_W-1:0]     dv_root_ff  [1:N];
   logic [nmds_pkg::ROOT_W-1:0]     dv_root_in  [1:N];
   rem_type                         dv_rem_ff   [1:N];
   rem_type                         dv_rem_in   [1:N];
   quot_type                        dv_quot_ff  [1:N];
   quot_type                        dv_quot_in  [1:N];

   // operands seen by each step
   logic                            src_valid [0:N-1];
   nmds_pkg::nmds_frag_type         src_frag  [0:N-1];
   logic [nmds_pkg::ROOT_W-1:0]     src_root  [0:N-1];
   rem_type                         src_rem   [0:N-1];
   quot_type                        src_quot  [0:N-1];

   // quotient fits 15 bits, so the top of the dividend is already below the root
   assign src_valid[0] = in_valid;
   assign src_frag[0]  = in_frag;
   assign src_root[0]  = in_root;
   assign src_quot[0]  = '0;
   for (genvar k = 0; k < nmds_pkg::NUM_AXES; k++) begin : g_pre
      assign src_rem[0][k] = nmds_pkg::ROOT_W'({in_frag.mag[k], {nmds_pkg::DIV_PRE{1'b0}}});
   end

   for (genvar s = 1; s < N; s++) begin : g_src
      assign src_valid[s] = dv_valid_ff[s];
      assign src_frag[s]  = dv_frag_ff[s];
      assign src_root[s]  = dv_root_ff[s];
      assign src_rem[s]   = dv_rem_ff[s];
      assign src_quot[s]  = dv_quot_ff[s];
   end

   for (genvar s = 0; s < N; s++) begin : g_step
      assign dv_valid_in[s+1] = src_valid[s];
      assign dv_frag_in[s+1]  = src_frag[s];
      assign dv_root_in[s+1]  = src_root[s];
      for (genvar k = 0; k < nmds_pkg::NUM_AXES; k++) begin : g_lane
         logic [nmds_pkg::ROOT_W:0] cur;
         logic [nmds_pkg::ROOT_W:0] diff;
         logic                      take;

         assign cur  = {src_rem[s][k], 1'b0};
         assign diff = cur - {1'b0, src_root[s]};
         assign take = (cur >= {1'b0, src_root[s]});
         assign dv_rem_in[s+1][k]  = take ? diff[nmds_pkg::ROOT_W-1:0]
                                          : cur[nmds_pkg::ROOT_W-1:0];
         assign dv_quot_in[s+1][k] = {src_quot[s][k][N-2:0], take};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_valid_ff <= '{default: 1'b0};
      end else if (enable) begin
         dv_valid_ff <= dv_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         dv_frag_ff <= dv_frag_in;
         dv_root_ff <= dv_root_in;
         dv_rem_ff  <= dv_rem_in;
         dv_quot_ff <= dv_quot_in;
      end
   end

   assign out_valid = dv_valid_ff[N];
   assign out_frag  = dv_frag_ff[N];
   assign out_quot  = dv_quot_ff[N];

endmodule

@@ design/nmds_light.sv @@
// Lighting stages: dot product with the light, gain, clamp and diffuse scaling.
module nmds_light (
   input  logic                                                    clock,
   input  logic                                                    reset,
   input  logic                                                    enable,
   input  nmds_pkg::nmds_light_type                                light,
   input  logic                                                    in_valid,
   input  nmds_pkg::nmds_frag_type                                 in_frag,
   input  logic [nmds_pkg::NUM_AXES-1:0][nmds_pkg::QUOT_W-1:0]     in_quot,
   output logic                                                    out_valid,
   output nmds_pkg::nmds_rgb_type                                  out_rgb
);

   logic signed [nmds_pkg::CFG_W-1:0]    comp [nmds_pkg::NUM_AXES];
   logic signed [nmds_pkg::CFG_W-1:0]    dir  [nmds_pkg::NUM_AXES];

   logic                                 l1_valid_ff, l1_valid_in;
   nmds_pkg::nmds_rgb_type               l1_rgb_ff, l1_rgb_in;
   logic signed [nmds_pkg::PROD_W-1:0]   l1_prod_ff [nmds_pkg::NUM_AXES];
   logic signed [nmds_pkg::PROD_W-1:0]   l1_prod_in [nmds_pkg::NUM_AXES];

   logic                                 l2_valid_ff, l2_valid_in;
   nmds_pkg::nmds_rgb_type               l2_rgb_ff, l2_rgb_in;
   logic signed [nmds_pkg::PROD_W-1:0]   l2_dot_ff, l2_dot_in;

   logic                                 l3_valid_ff, l3_valid_in;
   nmds_pkg::nmds_rgb_type               l3_rgb_ff, l3_rgb_in;
   logic [nmds_pkg::SCALED_W-1:0]        l3_scaled_ff, l3_scaled_in;

   logic [nmds_pkg::SCALED_W-nmds_pkg::GAIN_SHIFT-1:0] intens_full;
   logic [nmds_pkg::INTENS_W-1:0]        intens;
   logic [nmds_pkg::SHADE_W-1:0]         shade_r, shade_g, shade_b;

   assign dir[0] = light.dir_x;
   assign dir[1] = light.dir_y;
   assign dir[2] = light.dir_z;

   // signed unit component times light direction, Q2.28
   always_comb begin
      for (int k = 0; k < nmds_pkg::NUM_AXES; k++) begin
         comp[k] = signed'({1'b0, in_quot[k]});
         if (in_frag.neg[k]) begin
            comp[k] = -comp[k];
         end
         l1_prod_in[k] = comp[k] * dir[k];
      end
   end
   assign l1_valid_in = in_valid;
   assign l1_rgb_in   = in_frag.diffuse;

   // three terms of at most 2^29 each cannot overflow 32 bits
   assign l2_valid_in = l1_valid_ff;
   assign l2_rgb_in   = l1_rgb_ff;
   assign l2_dot_in   = l1_prod_ff[0] + l1_prod_ff[1] + l1_prod_ff[2];

   assign l3_valid_in  = l2_valid_ff;
   assign l3_rgb_in    = l2_rgb_ff;
   assign l3_scaled_in = (l2_dot_ff > 0)
                       ? nmds_pkg::SCALED_W'(l2_dot_ff[nmds_pkg::PROD_W-2:0])
                         * nmds_pkg::SCALED_W'(light.gain)
                       : '0;

   always_ff @(posedge clock) begin
      if (reset) begin
         l1_valid_ff <= 1'b0;
         l2_valid_ff <= 1'b0;
         l3_valid_ff <= 1'b0;
      end else if (enable) begin
         l1_valid_ff <= l1_valid_in;
         l2_valid_ff <= l2_valid_in;
         l3_valid_ff <= l3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         l1_rgb_ff    <= l1_rgb_in;
         l1_prod_ff   <= l1_prod_in;
         l2_rgb_ff    <= l2_rgb_in;
         l2_dot_ff    <= l2_dot_in;
         l3_rgb_ff    <= l3_rgb_in;
         l3_scaled_ff <= l3_scaled_in;
      end
   end

   // clamp to 1.0 and scale each channel, truncating
   assign intens_full = l3_scaled_ff[nmds_pkg::SCALED_W-1:nmds_pkg::GAIN_SHIFT];
   assign intens = (intens_full > (nmds_pkg::SCALED_W - nmds_pkg::GAIN_SHIFT)'(nmds_pkg::INTENS_ONE))
                 ? nmds_pkg::INTENS_ONE
                 : intens_full[nmds_pkg::INTENS_W-1:0];

   assign shade_r = nmds_pkg::SHADE_W'(l3_rgb_ff.red)   * nmds_pkg::SHADE_W'(intens);
   assign shade_g = nmds_pkg::SHADE_W'(l3_rgb_ff.green) * nmds_pkg::SHADE_W'(intens);
   assign shade_b = nmds_pkg::SHADE_W'(l3_rgb_ff.blue)  * nmds_pkg::SHADE_W'(intens);

   assign out_valid     = l3_valid_ff;
   assign out_rgb.red   = shade_r[nmds_pkg::FRAC_W +: nmds_pkg::COMP_W];
   assign out_rgb.green = shade_g[nmds_pkg::FRAC_W +: nmds_pkg::COMP_W];
   assign out_rgb.blue  = shade_b[nmds_pkg::FRAC_W +: nmds_pkg::COMP_W];

endmodule

@@ design/normal_map_diffuse_shade.sv @@
// Normal-mapped Lambert diffuse shader: top level with config registers and output buffer.
//
// Takes one word per clock while req_ch.ready is high and returns one shaded word
// per input word, in order. From acceptance to rsp valid a word passes one stage for
// the squared normal length, 23 square-root stages (one root bit each), 15 divider
// stages (one quotient bit each, three lanes), three lighting stages and the output
// register. rsp backpressure is absorbed by a two-entry output buffer, and req_ch.ready
// drops only while its second entry is full. Sustained rate is one word per clock while
// it is empty. The light registers are meant to be written while no word is in flight.

module normal_map_diffuse_shade (
   input  logic                                  clock,
   input  logic                                  reset,
   nmds_req_if.sink                              req_ch,
   nmds_rsp_if.source                            rsp_ch,
   input  logic                                  csr_write_enable,
   input  logic [nmds_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [nmds_pkg::CFG_W-1:0]            csr_write_data
);

   nmds_pkg::nmds_light_type      light_ff, light_in;
   nmds_pkg::nmds_frag_type       in_frag;
   logic                          enable;
   logic                          in_valid;

   logic                          sq_valid;
   nmds_pkg::nmds_frag_type       sq_frag;
   logic [nmds_pkg::ROOT_W-1:0]   sq_root;

   logic                          dv_valid;
   nmds_pkg::nmds_frag_type       dv_frag;
   logic [nmds_pkg::NUM_AXES-1:0][nmds_pkg::QUOT_W-1:0] dv_quot;

   logic                          lt_valid;
   nmds_pkg::nmds_rgb_type        lt_rgb;

   logic                          rsp_valid_ff, rsp_valid_in;
   nmds_pkg::nmds_rgb_type        rsp_rgb_ff, rsp_rgb_in;
   logic                          skid_valid_ff, skid_valid_in;
   nmds_pkg::nmds_rgb_type        skid_rgb_ff, skid_rgb_in;

   // configuration registers
   always_comb begin
      light_in = light_ff;
      if (csr_write_enable) begin
         unique case (nmds_pkg::nmds_csr_type'(csr_index))
            nmds_pkg::CSR_LIGHT_DIR_X: light_in.dir_x = csr_write_data;
            nmds_pkg::CSR_LIGHT_DIR_Y: light_in.dir_y = csr_write_data;
            nmds_pkg::CSR_LIGHT_DIR_Z: light_in.dir_z = csr_write_data;
            nmds_pkg::CSR_LIGHT_GAIN:  light_in.gain  = csr_write_data;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_ff <= nmds_pkg::LIGHT_RESET;
      end else begin
         light_ff <= light_in;
      end
   end

   // the whole pipeline advances unless the buffer's second entry is occupied
   assign enable       = !skid_valid_ff;
   assign req_ch.ready = enable;
   assign in_valid     = req_ch.valid && enable;

   // decode 2c-255 into sign and magnitude
   assign in_frag.neg[0]       = ~req_ch.normal_red[nmds_pkg::COMP_W-1];
   assign in_frag.neg[1]       = ~req_ch.normal_green[nmds_pkg::COMP_W-1];
   assign in_frag.neg[2]       = ~req_ch.normal_blue[nmds_pkg::COMP_W-1];
   assign in_frag.mag[0]       = nmds_pkg::nmds_mag(req_ch.normal_red);
   assign in_frag.mag[1]       = nmds_pkg::nmds_mag(req_ch.normal_green);
   assign in_frag.mag[2]       = nmds_pkg::nmds_mag(req_ch.normal_blue);
   assign in_frag.diffuse.red   = req_ch.diffuse_red;
   assign in_frag.diffuse.green = req_ch.diffuse_green;
   assign in_frag.diffuse.blue  = req_ch.diffuse_blue;

   nmds_sqrt u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (in_valid),
      .in_frag   (in_frag),
      .out_valid (sq_valid),
      .out_frag  (sq_frag),
      .out_root  (sq_root)
   );

   nmds_div u_div (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .in_valid  (sq_valid),
      .in_frag   (sq_frag),
      .in_root   (sq_root),
      .out_valid (dv_valid),
      .out_frag  (dv_frag),
      .out_quot  (dv_quot)
   );

   nmds_light u_light (
      .clock     (clock),
      .reset     (reset),
      .enable    (enable),
      .light     (light_ff),
      .in_valid  (dv_valid),
      .in_frag   (dv_frag),
      .in_quot   (dv_quot),
      .out_valid (lt_valid),
      .out_rgb   (lt_rgb)
   );

   // output register plus skid entry
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_rgb_in    = rsp_rgb_ff;
      skid_valid_in = skid_valid_ff;
      skid_rgb_in   = skid_rgb_ff;
      priority if (skid_valid_ff) begin
         if (rsp_ch.ready) begin
            rsp_rgb_in    = skid_rgb_ff;
            skid_valid_in = 1'b0;
         end
      end else if (rsp_valid_ff && !rsp_ch.ready) begin
         if (lt_valid) begin
            skid_valid_in = 1'b1;
            skid_rgb_in   = lt_rgb;
         end
      end else begin
         rsp_valid_in = lt_valid;
         rsp_rgb_in   = lt_rgb;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_rgb_ff  <= rsp_rgb_in;
      skid_rgb_ff <= skid_rgb_in;
   end

   assign rsp_ch.valid        = rsp_valid_ff;
   assign rsp_ch.shaded_red   = rsp_rgb_ff.red;
   assign rsp_ch.shaded_green = rsp_rgb_ff.green;
   assign rsp_ch.shaded_blue  = rsp_rgb_ff.blue;

   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid entry holds a word while the output register is empty");

   a_skid_drains: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff && rsp_ch.ready |=> !skid_valid_ff)
      else $error("skid entry not released after the output was taken");

   a_skid_catches: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_ch.ready && !skid_valid_ff && lt_valid |=> skid_valid_ff)
      else $error("pipeline word dropped while the output was stalled");

endmodule
